// ===== design/ts_header_and_psi_parser_top_defines.svh =====
// Assertion macros for the transport stream parser checker.
// Used by tspp_checker.sv; no other dependencies.
`ifndef TS_HEADER_AND_PSI_PARSER_TOP_DEFINES_SVH
`define TS_HEADER_AND_PSI_PARSER_TOP_DEFINES_SVH
// clocked check, disabled while reset is high
`define TSPP_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("tspp assertion failed");
// clocked check, also active during reset
`define TSPP_ASSERT_RST(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("tspp reset assertion failed");
`endif

// ===== design/tspp_pkg.sv =====
// Package for the transport stream header and PSI parser.
// Types, phase encoding and result kinds; no dependencies.
`default_nettype none
package tspp_pkg;
   localparam int PacketBytesDef = 188;
   localparam int MaxSectionLengthDef = 1021;

   localparam logic [7:0] SyncByte = 8'h47;
   localparam logic [7:0] PmtTableId = 8'h02;
   localparam logic [12:0] MapPidReset = 13'h1FFF;

   typedef enum logic [2:0] {
      KIND_HEADER    = 3'd0,
      KIND_PROGRAM   = 3'd1,
      KIND_STREAM    = 3'd2,
      KIND_PAT_END   = 3'd3,
      KIND_PMT_END   = 3'd4,
      KIND_SYNC_ERR  = 3'd5,
      KIND_NO_START  = 3'd6,
      KIND_BAD_SECT  = 3'd7
   } kind_type;

   typedef enum logic [4:0] {
      PH_IDLE, PH_HDR1, PH_HDR2, PH_HDR3, PH_AF_LEN, PH_AF_SKIP, PH_POINTER,
      PH_PTR_SKIP, PH_TABLE, PH_LEN_HI, PH_LEN_LO, PH_ID_HI, PH_ID_LO, PH_VER,
      PH_SECN, PH_LAST, PH_PCR_HI, PH_PCR_LO, PH_PIL_HI, PH_PIL_LO, PH_INFO_SKIP,
      PH_PE0, PH_PE1, PH_PE2, PH_PE3, PH_ST0, PH_ST1, PH_ST2, PH_ST3, PH_ST4,
      PH_ES_SKIP, PH_CRC
   } phase_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [12:0] packet_id;
      logic        error_indicator;
      logic        start_indicator;
      logic        priority_bit;
      logic [1:0]  scrambling;
      logic [1:0]  field_control;
      logic [3:0]  continuity;
      logic [15:0] entry_number;
      logic [12:0] entry_pid;
      logic [4:0]  section_version;
      logic [31:0] section_crc;
   } result_type;
endpackage
`default_nettype wire

// ===== design/tspp_if.sv =====
// Channel interfaces for the parser: byte input and result output.
// Depends on tspp_pkg.
`default_nettype none
interface tspp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       first_of_packet;
   modport source (output valid, output data_byte, output first_of_packet, input ready);
   modport sink (input valid, input data_byte, input first_of_packet, output ready);
endinterface

interface tspp_rsp_if import tspp_pkg::*;;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [12:0] packet_id;
   logic        error_indicator;
   logic        start_indicator;
   logic        priority_bit;
   logic [1:0]  scrambling;
   logic [1:0]  field_control;
   logic [3:0]  continuity;
   logic [15:0] entry_number;
   logic [12:0] entry_pid;
   logic [4:0]  section_version;
   logic [31:0] section_crc;
   modport source (output valid, output kind, output packet_id, output error_indicator,
      output start_indicator, output priority_bit, output scrambling,
      output field_control, output continuity, output entry_number, output entry_pid,
      output section_version, output section_crc, input ready);
   modport sink (input valid, input kind, input packet_id, input error_indicator,
      input start_indicator, input priority_bit, input scrambling,
      input field_control, input continuity, input entry_number, input entry_pid,
      input section_version, input section_crc, output ready);
endinterface
`default_nettype wire

// ===== design/ts_header_and_psi_parser_top.sv =====
// Transport stream header and PAT/PMT section parser: takes one packet byte per
// item, at most one result item per byte. Accepts a byte every cycle; the result
// register is written on the cycle after the byte is taken, and a new byte is taken
// whenever that register is empty or being drained. Depends on tspp_pkg, tspp_if.
`default_nettype none
module ts_header_and_psi_parser_top
   import tspp_pkg::*;
#(
   parameter int PACKET_BYTES = PacketBytesDef,
   parameter int MAX_SECTION_LENGTH = MaxSectionLengthDef
) (
   input  wire logic        clock,
   input  wire logic        reset,
   tspp_req_if.sink         req,
   tspp_rsp_if.source       rsp,
   input  wire logic        csr_we,
   input  wire logic [12:0] csr_wdata
);
   logic [12:0] map_pid_ff;
   logic [7:0]  pos_ff, pos_in;
   phase_type   phase_ff, phase_in;
   logic [11:0] left_ff, left_in;
   logic [11:0] skip_ff, skip_in;
   logic [31:0] shift_ff, shift_in;
   logic [23:0] hdr_ff, hdr_in;
   logic        is_map_ff, is_map_in;
   logic [15:0] entry_ff, entry_in;
   logic [4:0]  ver_ff, ver_in;
   logic [12:0] pcr_ff, pcr_in;
   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_ff, rsp_in;
   logic        accept;

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept = req.valid && req.ready;

   always_comb begin
      logic [7:0]  b;
      logic        emit;
      logic [2:0]  kind;
      logic [23:0] hh;
      logic [15:0] num;
      logic [12:0] epid;
      logic [4:0]  ev;
      logic [31:0] crc;
      logic [12:0] pid;
      logic [1:0]  afc;
      logic [11:0] len;
      b = req.data_byte;
      emit = 1'b0;
      kind = KIND_HEADER;
      num = '0;
      epid = '0;
      ev = '0;
      crc = '0;
      pid = '0;
      afc = '0;
      len = '0;
      pos_in = pos_ff;
      phase_in = phase_ff;
      left_in = left_ff;
      skip_in = skip_ff;
      shift_in = shift_ff;
      hdr_in = hdr_ff;
      is_map_in = is_map_ff;
      entry_in = entry_ff;
      ver_in = ver_ff;
      pcr_in = pcr_ff;
      if (req.first_of_packet) begin
         pos_in = 8'd1;
         shift_in = {24'd0, b};
         if (b != SyncByte) begin
            phase_in = PH_IDLE;
            hdr_in = '0;
            emit = 1'b1;
            kind = KIND_SYNC_ERR;
         end else begin
            phase_in = PH_HDR1;
         end
      end else if (pos_ff >= 8'(PACKET_BYTES)) begin
         phase_in = PH_IDLE;
      end else begin
         pos_in = pos_ff + 8'd1;
         if (phase_ff != PH_IDLE) begin
            shift_in = {shift_ff[23:0], b};
            if (phase_ff >= PH_ID_HI) left_in = left_ff - 12'd1;
            unique case (phase_ff)
               PH_HDR1: phase_in = PH_HDR2;
               PH_HDR2: phase_in = PH_HDR3;
               PH_HDR3: begin
                  pid = {shift_in[20:16], shift_in[15:8]};
                  afc = b[5:4];
                  hdr_in = {b[3:0], afc, b[7:6], shift_in[23:21], pid};
                  hdr_in[13] = shift_in[23];
                  hdr_in[14] = shift_in[22];
                  hdr_in[15] = shift_in[21];
                  is_map_in = (pid != 13'd0);
                  if (!(afc[0] && (pid == 13'd0 || pid == map_pid_ff))) phase_in = PH_IDLE;
                  else phase_in = afc[1] ? PH_AF_LEN : PH_POINTER;
                  emit = 1'b1;
                  kind = KIND_HEADER;
               end
               PH_AF_LEN: begin
                  skip_in = {4'd0, b};
                  phase_in = (b == 8'd0) ? PH_POINTER : PH_AF_SKIP;
               end
               PH_AF_SKIP, PH_PTR_SKIP, PH_INFO_SKIP, PH_ES_SKIP: begin
                  skip_in = skip_ff - 12'd1;
                  if (skip_in == 12'd0) begin
                     if (phase_ff == PH_AF_SKIP) phase_in = PH_POINTER;
                     else if (phase_ff == PH_PTR_SKIP) phase_in = PH_TABLE;
                     else phase_in = PH_ST0;
                  end
               end
               PH_POINTER: begin
                  if (!hdr_ff[14]) begin
                     phase_in = PH_IDLE;
                     emit = 1'b1;
                     kind = KIND_NO_START;
                  end else begin
                     skip_in = {4'd0, b};
                     phase_in = (b == 8'd0) ? PH_TABLE : PH_PTR_SKIP;
                  end
               end
               PH_TABLE: begin
                  if (is_map_ff && b != PmtTableId) begin
                     phase_in = PH_IDLE;
                     emit = 1'b1;
                     kind = KIND_BAD_SECT;
                  end else phase_in = PH_LEN_HI;
               end
               PH_LEN_HI: begin
                  if (!is_map_ff && !b[7]) begin
                     phase_in = PH_IDLE;
                     emit = 1'b1;
                     kind = KIND_BAD_SECT;
                  end else phase_in = PH_LEN_LO;
               end
               PH_LEN_LO: begin
                  len = shift_in[11:0];
                  if (len > 12'(MAX_SECTION_LENGTH) || len < (is_map_ff ? 12'd13 : 12'd9))
                  begin
                     phase_in = PH_IDLE;
                     emit = 1'b1;
                     kind = KIND_BAD_SECT;
                  end else begin
                     left_in = len;
                     phase_in = PH_ID_HI;
                  end
               end
               PH_ID_HI: phase_in = PH_ID_LO;
               PH_ID_LO: begin
                  entry_in = shift_in[15:0];
                  phase_in = PH_VER;
               end
               PH_VER: begin
                  ver_in = b[5:1];
                  phase_in = PH_SECN;
               end
               PH_SECN: phase_in = PH_LAST;
               PH_LAST: phase_in = is_map_ff ? PH_PCR_HI : PH_PE0;
               PH_PCR_HI: phase_in = PH_PCR_LO;
               PH_PCR_LO: begin
                  pcr_in = shift_in[12:0];
                  phase_in = PH_PIL_HI;
               end
               PH_PIL_HI: phase_in = PH_PIL_LO;
               PH_PIL_LO, PH_ST4: begin
                  skip_in = shift_in[11:0];
                  if (skip_in == 12'd0) phase_in = PH_ST0;
                  else phase_in = (phase_ff == PH_PIL_LO) ? PH_INFO_SKIP : PH_ES_SKIP;
               end
               PH_PE0: phase_in = PH_PE1;
               PH_PE1: phase_in = PH_PE2;
               PH_PE2: phase_in = PH_PE3;
               PH_PE3: begin
                  emit = 1'b1;
                  kind = KIND_PROGRAM;
                  num = shift_in[31:16];
                  epid = shift_in[12:0];
                  phase_in = PH_PE0;
               end
               PH_ST0: phase_in = PH_ST1;
               PH_ST1: phase_in = PH_ST2;
               PH_ST2: begin
                  emit = 1'b1;
                  kind = KIND_STREAM;
                  num = {8'd0, shift_in[23:16]};
                  epid = shift_in[12:0];
                  phase_in = PH_ST3;
               end
               PH_ST3: phase_in = PH_ST4;
               PH_CRC: begin
                  if (left_in == 12'd0) begin
                     phase_in = PH_IDLE;
                     emit = 1'b1;
                     kind = is_map_ff ? KIND_PMT_END : KIND_PAT_END;
                     num = entry_ff;
                     epid = is_map_ff ? pcr_ff : 13'd0;
                     ev = ver_ff;
                     crc = shift_in;
                  end
               end
               default: phase_in = PH_IDLE;
            endcase
            if (phase_in >= PH_ID_HI && phase_in != PH_CRC && left_in == 12'd4)
               phase_in = PH_CRC;
         end
      end
      hh = hdr_in;
      rsp_in = '{kind: kind, packet_id: hh[12:0], error_indicator: hh[13],
         start_indicator: hh[14], priority_bit: hh[15], scrambling: hh[17:16],
         field_control: hh[19:18], continuity: hh[23:20], entry_number: num,
         entry_pid: epid, section_version: ev, section_crc: crc};
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      if (accept && emit) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_pid_ff <= MapPidReset;
         pos_ff <= '0;
         phase_ff <= PH_IDLE;
         left_ff <= '0;
         skip_ff <= '0;
         shift_ff <= '0;
         hdr_ff <= '0;
         is_map_ff <= 1'b0;
         entry_ff <= '0;
         ver_ff <= '0;
         pcr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) map_pid_ff <= csr_wdata;
         if (accept) begin
            pos_ff <= pos_in;
            phase_ff <= phase_in;
            left_ff <= left_in;
            skip_ff <= skip_in;
            shift_ff <= shift_in;
            hdr_ff <= hdr_in;
            is_map_ff <= is_map_in;
            entry_ff <= entry_in;
            ver_ff <= ver_in;
            pcr_ff <= pcr_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && (!rsp_valid_ff || rsp.ready)) rsp_ff <= rsp_in;
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.kind = rsp_ff.kind;
   assign rsp.packet_id = rsp_ff.packet_id;
   assign rsp.error_indicator = rsp_ff.error_indicator;
   assign rsp.start_indicator = rsp_ff.start_indicator;
   assign rsp.priority_bit = rsp_ff.priority_bit;
   assign rsp.scrambling = rsp_ff.scrambling;
   assign rsp.field_control = rsp_ff.field_control;
   assign rsp.continuity = rsp_ff.continuity;
   assign rsp.entry_number = rsp_ff.entry_number;
   assign rsp.entry_pid = rsp_ff.entry_pid;
   assign rsp.section_version = rsp_ff.section_version;
   assign rsp.section_crc = rsp_ff.section_crc;
endmodule
`default_nettype wire

// ===== design/tspp_checker.sv =====
// Port-level checks for the parser top level, bound to it below.
// Depends on tspp_pkg and the assertion macro header.
`default_nettype none
`include "ts_header_and_psi_parser_top_defines.svh"
module tspp_checker
   import tspp_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic [7:0]  req_data_byte,
   input wire logic        req_first_of_packet,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [2:0]  rsp_kind,
   input wire logic [12:0] rsp_packet_id
);
   logic take;
   assign take = req_valid && req_ready;

   `TSPP_ASSERT(a_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind))
   `TSPP_ASSERT_RST(a_reset_empty, $past(reset) |-> !rsp_valid)
   `TSPP_ASSERT(a_sync_err, take && req_first_of_packet && req_data_byte != SyncByte
      |=> rsp_valid && rsp_kind == KIND_SYNC_ERR)
   `TSPP_ASSERT(a_sync_ok, take && req_first_of_packet && req_data_byte == SyncByte
      && (!rsp_valid || rsp_ready) |=> !rsp_valid)
   `TSPP_ASSERT(a_err_pid, rsp_valid && rsp_kind == KIND_SYNC_ERR |-> rsp_packet_id == 13'd0)
endmodule

bind ts_header_and_psi_parser_top tspp_checker u_tspp_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req.valid),
   .req_ready(req.ready),
   .req_data_byte(req.data_byte),
   .req_first_of_packet(req.first_of_packet),
   .rsp_valid(rsp.valid),
   .rsp_ready(rsp.ready),
   .rsp_kind(rsp.kind),
   .rsp_packet_id(rsp.packet_id)
);
`default_nettype wire

// ===== tb/sv/ts_header_and_psi_parser_top_tb.sv =====
// Self-checking testbench for ts_header_and_psi_parser_top: packet bytes in, parse results out.
// It keeps its own byte-level model of the header and PAT/PMT parser and checks every result.
// Depends on tspp_pkg, tspp_if and the parser top level.
module ts_header_and_psi_parser_top_tb;
   import tspp_pkg::*;

   localparam int PacketLen = 188;
   localparam int MaxSectLen = 1021;

   logic clock;
   logic reset;
   logic csr_we;
   logic [12:0] csr_wdata;

   tspp_req_if req_ch();
   tspp_rsp_if rsp_ch();

   ts_header_and_psi_parser_top dut (
      .clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   typedef struct packed {
      logic [7:0] data_byte;
      logic       first_of_packet;
   } byte_item_t;

   byte_item_t pending_bytes[$];
   result_type expected_results[$];
   int fails;
   int items_queued;
   logic req_taken, rsp_taken;

   // parser model state
   logic [12:0] map_pid;
   logic [7:0]  pos;
   phase_type   ph;
   logic [11:0] left_bytes;
   logic [11:0] skip_cnt;
   logic [31:0] shift_reg;
   logic [23:0] hdr;
   logic        is_map;
   logic [15:0] lat_entry;
   logic [4:0]  lat_ver;
   logic [12:0] lat_pcr;

   function automatic result_type form_result(kind_type k, bit with_hdr, logic [15:0] num,
                                              logic [12:0] pid, logic [4:0] ver,
                                              logic [31:0] crc);
      result_type r;
      logic [23:0] h;
      h = with_hdr ? hdr : 24'd0;
      r.kind = k;
      r.packet_id = h[12:0];
      r.error_indicator = h[13];
      r.start_indicator = h[14];
      r.priority_bit = h[15];
      r.scrambling = h[17:16];
      r.field_control = h[19:18];
      r.continuity = h[23:20];
      r.entry_number = num;
      r.entry_pid = pid;
      r.section_version = ver;
      r.section_crc = crc;
      return r;
   endfunction

   function automatic bit parse_byte(input logic [7:0] b, input logic first,
                                     output result_type r);
      bit hit;
      logic [7:0] b1;
      logic [12:0] pid;
      logic [1:0] afc;
      logic [11:0] len;
      hit = 0;
      r = '0;
      if (first) begin
         pos = 8'd1;
         shift_reg = {24'd0, b};
         if (b != SyncByte) begin
            ph = PH_IDLE;
            hdr = '0;
            r = form_result(KIND_SYNC_ERR, 0, 0, 0, 0, 0);
            return 1;
         end
         ph = PH_HDR1;
         return 0;
      end
      if (pos >= PacketLen) begin
         ph = PH_IDLE;
         return 0;
      end
      pos = pos + 8'd1;
      if (ph == PH_IDLE) return 0;
      shift_reg = {shift_reg[23:0], b};
      if (ph >= PH_ID_HI) left_bytes = left_bytes - 12'd1;
      case (ph)
         PH_HDR1: ph = PH_HDR2;
         PH_HDR2: ph = PH_HDR3;
         PH_HDR3: begin
            b1 = shift_reg[23:16];
            pid = {b1[4:0], shift_reg[15:8]};
            afc = b[5:4];
            hdr = {b[3:0], afc, b[7:6], b1[5], b1[6], b1[7], pid};
            is_map = (pid != 0);
            if (!(afc[0] && (pid == 0 || pid == map_pid))) ph = PH_IDLE;
            else ph = afc[1] ? PH_AF_LEN : PH_POINTER;
            r = form_result(KIND_HEADER, 1, 0, 0, 0, 0);
            hit = 1;
         end
         PH_AF_LEN: begin
            skip_cnt = {4'd0, b};
            ph = (b == 0) ? PH_POINTER : PH_AF_SKIP;
         end
         PH_AF_SKIP: begin
            skip_cnt = skip_cnt - 12'd1;
            if (skip_cnt == 0) ph = PH_POINTER;
         end
         PH_POINTER: begin
            if (!hdr[14]) begin
               ph = PH_IDLE;
               r = form_result(KIND_NO_START, 1, 0, 0, 0, 0);
               hit = 1;
            end else begin
               skip_cnt = {4'd0, b};
               ph = (b == 0) ? PH_TABLE : PH_PTR_SKIP;
            end
         end
         PH_PTR_SKIP: begin
            skip_cnt = skip_cnt - 12'd1;
            if (skip_cnt == 0) ph = PH_TABLE;
         end
         PH_TABLE: begin
            if (is_map && b != PmtTableId) begin
               ph = PH_IDLE;
               r = form_result(KIND_BAD_SECT, 1, 0, 0, 0, 0);
               hit = 1;
            end else ph = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            if (!is_map && !b[7]) begin
               ph = PH_IDLE;
               r = form_result(KIND_BAD_SECT, 1, 0, 0, 0, 0);
               hit = 1;
            end else ph = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            len = shift_reg[11:0];
            if (len > MaxSectLen || len < (is_map ? 13 : 9)) begin
               ph = PH_IDLE;
               r = form_result(KIND_BAD_SECT, 1, 0, 0, 0, 0);
               hit = 1;
            end else begin
               left_bytes = len;
               ph = PH_ID_HI;
            end
         end
         PH_ID_HI: ph = PH_ID_LO;
         PH_ID_LO: begin
            lat_entry = shift_reg[15:0];
            ph = PH_VER;
         end
         PH_VER: begin
            lat_ver = b[5:1];
            ph = PH_SECN;
         end
         PH_SECN: ph = PH_LAST;
         PH_LAST: ph = is_map ? PH_PCR_HI : PH_PE0;
         PH_PCR_HI: ph = PH_PCR_LO;
         PH_PCR_LO: begin
            lat_pcr = shift_reg[12:0];
            ph = PH_PIL_HI;
         end
         PH_PIL_HI: ph = PH_PIL_LO;
         PH_PIL_LO, PH_ST4: begin
            skip_cnt = shift_reg[11:0];
            if (skip_cnt == 0) ph = PH_ST0;
            else ph = (ph == PH_PIL_LO) ? PH_INFO_SKIP : PH_ES_SKIP;
         end
         PH_INFO_SKIP, PH_ES_SKIP: begin
            skip_cnt = skip_cnt - 12'd1;
            if (skip_cnt == 0) ph = PH_ST0;
         end
         PH_PE0: ph = PH_PE1;
         PH_PE1: ph = PH_PE2;
         PH_PE2: ph = PH_PE3;
         PH_PE3: begin
            r = form_result(KIND_PROGRAM, 1, shift_reg[31:16], shift_reg[12:0], 0, 0);
            hit = 1;
            ph = PH_PE0;
         end
         PH_ST0: ph = PH_ST1;
         PH_ST1: ph = PH_ST2;
         PH_ST2: begin
            r = form_result(KIND_STREAM, 1, {8'd0, shift_reg[23:16]}, shift_reg[12:0], 0, 0);
            hit = 1;
            ph = PH_ST3;
         end
         PH_ST3: ph = PH_ST4;
         PH_CRC: begin
            if (left_bytes == 0) begin
               ph = PH_IDLE;
               if (is_map)
                  r = form_result(KIND_PMT_END, 1, lat_entry, lat_pcr, lat_ver, shift_reg);
               else
                  r = form_result(KIND_PAT_END, 1, lat_entry, 0, lat_ver, shift_reg);
               hit = 1;
            end
         end
         default: ph = PH_IDLE;
      endcase
      if (ph >= PH_ID_HI && ph != PH_CRC && left_bytes == 12'd4) ph = PH_CRC;
      return hit;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got 0x%0h expected 0x%0h at %0t", what, got, want, $time);
      fails++;
   endtask

   // clock and reset
   initial begin
      clock = 0;
      reset = 1;
      csr_we = 0;
      csr_wdata = '0;
      req_ch.valid = 0;
      req_ch.data_byte = '0;
      req_ch.first_of_packet = 0;
      rsp_ch.ready = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 0;
   end

   // model update and result check
   always @(posedge clock) begin
      result_type r, got;
      if (reset) begin
         map_pid = MapPidReset;
         pos = 0; ph = PH_IDLE; left_bytes = 0; skip_cnt = 0; shift_reg = 0;
         hdr = 0; is_map = 0; lat_entry = 0; lat_ver = 0; lat_pcr = 0;
         req_taken <= 0;
         rsp_taken <= 0;
      end else begin
         req_taken <= req_ch.valid && req_ch.ready;
         rsp_taken <= rsp_ch.valid && rsp_ch.ready;
         if (req_ch.valid && req_ch.ready)
            if (parse_byte(req_ch.data_byte, req_ch.first_of_packet, r))
               expected_results.push_back(r);
         if (csr_we) map_pid = csr_wdata;
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.kind = rsp_ch.kind;
            got.packet_id = rsp_ch.packet_id;
            got.error_indicator = rsp_ch.error_indicator;
            got.start_indicator = rsp_ch.start_indicator;
            got.priority_bit = rsp_ch.priority_bit;
            got.scrambling = rsp_ch.scrambling;
            got.field_control = rsp_ch.field_control;
            got.continuity = rsp_ch.continuity;
            got.entry_number = rsp_ch.entry_number;
            got.entry_pid = rsp_ch.entry_pid;
            got.section_version = rsp_ch.section_version;
            got.section_crc = rsp_ch.section_crc;
            if (expected_results.size() == 0)
               report_mismatch("unexpected result kind", got.kind, 0);
            else begin
               r = expected_results.pop_front();
               if (got.kind !== r.kind) report_mismatch("kind", got.kind, r.kind);
               if (got.packet_id !== r.packet_id)
                  report_mismatch("packet_id", got.packet_id, r.packet_id);
               if (got.error_indicator !== r.error_indicator)
                  report_mismatch("error_indicator", got.error_indicator, r.error_indicator);
               if (got.start_indicator !== r.start_indicator)
                  report_mismatch("start_indicator", got.start_indicator, r.start_indicator);
               if (got.priority_bit !== r.priority_bit)
                  report_mismatch("priority_bit", got.priority_bit, r.priority_bit);
               if (got.scrambling !== r.scrambling)
                  report_mismatch("scrambling", got.scrambling, r.scrambling);
               if (got.field_control !== r.field_control)
                  report_mismatch("field_control", got.field_control, r.field_control);
               if (got.continuity !== r.continuity)
                  report_mismatch("continuity", got.continuity, r.continuity);
               if (got.entry_number !== r.entry_number)
                  report_mismatch("entry_number", got.entry_number, r.entry_number);
               if (got.entry_pid !== r.entry_pid)
                  report_mismatch("entry_pid", got.entry_pid, r.entry_pid);
               if (got.section_version !== r.section_version)
                  report_mismatch("section_version", got.section_version, r.section_version);
               if (got.section_crc !== r.section_crc)
                  report_mismatch("section_crc", got.section_crc, r.section_crc);
            end
         end
      end
   end

   // byte sender
   int send_gap;
   bit send_burst;
   always @(negedge clock) begin
      byte_item_t it;
      logic nxt_valid;
      nxt_valid = req_ch.valid;
      if (!reset) begin
         if (req_taken || !req_ch.valid) begin
            nxt_valid = 0;
            if (req_taken) begin
               if ($urandom_range(0, 49) == 0) send_burst = !send_burst;
               send_gap = send_burst ? 0 : $urandom_range(0, 16);
            end
            if (send_gap > 0) send_gap--;
            else if (pending_bytes.size() > 0) begin
               it = pending_bytes.pop_front();
               req_ch.data_byte <= it.data_byte;
               req_ch.first_of_packet <= it.first_of_packet;
               nxt_valid = 1;
            end
         end
      end
      req_ch.valid <= nxt_valid;
   end

   // result receiver, with one long hold-off while bytes keep coming
   int recv_stall;
   int long_hold;
   int results_seen;
   bit recv_burst;
   bit hold_done;
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_taken) begin
            results_seen++;
            if ($urandom_range(0, 29) == 0) recv_burst = !recv_burst;
            recv_stall = recv_burst ? 0 : $urandom_range(0, 16);
            if (results_seen == 40 && !hold_done) begin
               long_hold = 400;
               hold_done = 1;
            end
         end
         if (long_hold > 0) begin
            long_hold--;
            rsp_ch.ready <= 0;
         end else if (recv_stall > 0) begin
            recv_stall--;
            rsp_ch.ready <= 0;
         end else rsp_ch.ready <= 1;
      end
   end

   task automatic push_bytes(input logic [7:0] pkt[$]);
      foreach (pkt[i]) begin
         pending_bytes.push_back('{data_byte: pkt[i], first_of_packet: (i == 0)});
         items_queued++;
      end
   endtask

   task automatic push_loose(input logic [7:0] b);
      pending_bytes.push_back('{data_byte: b, first_of_packet: 1'b0});
      items_queued++;
   endtask

   // one packet, mostly a well-formed PAT or PMT section with random content
   task automatic gen_packet(input logic [12:0] mpid);
      logic [7:0] pkt[$];
      logic [7:0] body[$];
      logic [12:0] pid;
      logic [1:0] afc;
      logic [11:0] len;
      logic [7:0] tid;
      logic [7:0] len_hi;
      int sel, n, k, bad, esil;
      sel = $urandom_range(0, 99);
      if (sel < 5) begin
         pkt.push_back($urandom_range(0, 255));
         n = $urandom_range(0, 6);
         repeat (n) pkt.push_back($urandom_range(0, 255));
         push_bytes(pkt);
         return;
      end
      if (sel < 45) pid = 0;
      else if (sel < 80) pid = ($urandom_range(0, 4) == 0) ? 13'($urandom) : mpid;
      else pid = 13'($urandom);
      afc = ($urandom_range(0, 9) < 8) ? {1'($urandom_range(0, 3) == 0), 1'b1}
                                       : 2'($urandom);
      pkt.push_back(SyncByte);
      pkt.push_back({1'($urandom_range(0, 7) == 0), 1'($urandom_range(0, 9) != 0),
                     1'($urandom), pid[12:8]});
      pkt.push_back(pid[7:0]);
      pkt.push_back({2'($urandom), afc, 4'($urandom)});
      if (afc[1]) begin
         n = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 3);
         pkt.push_back(n);
         repeat (n) pkt.push_back($urandom_range(0, 255));
      end
      if (afc[0]) begin
         n = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 3);
         pkt.push_back(n);
         repeat (n) pkt.push_back($urandom_range(0, 255));
         repeat (5) body.push_back($urandom_range(0, 255));
         if (pid == 0 || pid != mpid) begin
            n = $urandom_range(0, 4);
            repeat (4 * n) body.push_back($urandom_range(0, 255));
            tid = $urandom_range(0, 255);
         end else begin
            body.push_back({3'($urandom), 5'($urandom)});
            body.push_back($urandom_range(0, 255));
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
            body.push_back({4'($urandom), 4'd0});
            body.push_back(n);
            repeat (n) body.push_back($urandom_range(0, 255));
            k = $urandom_range(0, 3);
            repeat (k) begin
               esil = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 2) : 0;
               body.push_back($urandom_range(0, 255));
               body.push_back({3'($urandom), 5'($urandom)});
               body.push_back($urandom_range(0, 255));
               body.push_back({4'($urandom), 4'd0});
               body.push_back(esil);
               repeat (esil) body.push_back($urandom_range(0, 255));
            end
            tid = PmtTableId;
         end
         repeat (4) body.push_back($urandom_range(0, 255));
         len = body.size();
         len_hi = {1'b1, 3'($urandom), len[11:8]};
         bad = $urandom_range(0, 39);
         case (bad)
            0: begin
               len = 12'($urandom);
               len_hi = {1'b1, 3'($urandom), len[11:8]};
            end
            1: tid = $urandom_range(0, 255);
            2: len_hi[7] = 0;
            3: begin
               len = $urandom_range(0, 12);
               len_hi = {1'b1, 3'($urandom), len[11:8]};
            end
            default: ;
         endcase
         pkt.push_back(tid);
         pkt.push_back(len_hi);
         pkt.push_back(len[7:0]);
         foreach (body[i]) pkt.push_back(body[i]);
      end
      n = $urandom_range(0, 3);
      repeat (n) pkt.push_back($urandom_range(0, 255));
      if ($urandom_range(0, 39) == 0)
         while (pkt.size() < PacketLen + 8) pkt.push_back($urandom_range(0, 255));
      push_bytes(pkt);
   endtask

   task automatic drain_and_write(input logic [12:0] v);
      wait (pending_bytes.size() == 0);
      @(posedge clock);
      while (req_ch.valid || expected_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
      csr_we <= 1;
      csr_wdata <= v;
      @(negedge clock);
      csr_we <= 0;
   endtask

   initial begin
      logic [12:0] settings[5];
      int target;
      fails = 0;
      items_queued = 0;
      send_gap = 0; send_burst = 0;
      recv_stall = 0; long_hold = 0; results_seen = 0; recv_burst = 0; hold_done = 0;
      settings = '{13'h1FFF, 13'h0000, 13'($urandom), 13'h0001, 13'h1FFF};
      @(negedge reset);
      // idle loose bytes, bad sync, untargeted header, no start, bad table id, no syntax bit
      push_loose(8'h00);
      push_loose(8'hFF);
      push_bytes('{8'hFF});
      push_bytes('{8'h47, 8'hF2, 8'h34, 8'hFF});
      push_bytes('{8'h47, 8'h00, 8'h00, 8'h10, 8'h00});
      push_bytes('{8'h47, 8'h5F, 8'hFF, 8'h10, 8'h00, 8'h05});
      push_bytes('{8'h47, 8'h40, 8'h00, 8'h10, 8'h00, 8'h00, 8'h00});
      foreach (settings[p]) begin
         drain_and_write(settings[p]);
         target = items_queued + 250;
         while (items_queued < target) gen_packet(settings[p]);
      end
      wait (pending_bytes.size() == 0);
      @(posedge clock);
      while (req_ch.valid || expected_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fails == 0 && expected_results.size() == 0)
         $display("ts_header_and_psi_parser_top regression: pass");
      else
         $display("ts_header_and_psi_parser_top regression: fail");
      $finish;
   end

   initial begin
      #5000000;
      $display("ts_header_and_psi_parser_top regression: fail");
      $finish;
   end
endmodule
